/* src/mmmed_pkg.sv */
// ----------------------------------------------------------------------------
// mmmed_pkg
// Shared sizes, status codes and control structs of the moving median filter.
// ----------------------------------------------------------------------------
package mmmed_pkg;

    localparam int CHANNELS     = 8;
    localparam int WINDOW_DEPTH = 16;

    localparam int DATA_W   = 32;
    localparam int CHAN_W   = 4;
    localparam int WIDTH_W  = 5;
    localparam int STATUS_W = 2;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W     = $clog2(WINDOW_DEPTH);
    localparam int CNT_W     = IDX_W;
    localparam int ADDR_W    = CH_W + IDX_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    localparam int S_TDATA_W = ((WIDTH_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_MEDIAN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PASS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic capture;
        logic update;
        logic rd_en;
        logic select;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic is_median;
        logic rd_last;
        logic out_free;
    } t_stat;

endpackage

/* src/mmmed_ram.sv */
// ----------------------------------------------------------------------------
// mmmed_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmmed_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mmmed_ctrl.sv */
// ----------------------------------------------------------------------------
// mmmed_ctrl
// Sequencer: capture, pointer update, window read, rank select, result push.
// ----------------------------------------------------------------------------
module mmmed_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mmmed_pkg::t_stat  i_stat,
    output mmmed_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_READ,
        S_DRAIN,
        S_SELECT,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_UPDATE;
            S_UPDATE: n_state = i_stat.is_median ? S_READ : S_HOLD;
            S_READ:   if (i_stat.rd_last) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_SELECT;
            S_SELECT: n_state = S_HOLD;
            S_HOLD:   if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.update   = (r_state == S_UPDATE);
    assign o_cmd.rd_en    = (r_state == S_READ);
    assign o_cmd.select   = (r_state == S_SELECT);
    assign o_cmd.push     = (r_state == S_HOLD) && i_stat.out_free;

endmodule

/* src/mmmed_dp.sv */
// ----------------------------------------------------------------------------
// mmmed_dp
// Datapath: ring pointers, window RAM with valid bits, rank lanes and the
// output register.
// ----------------------------------------------------------------------------
module mmmed_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mmmed_pkg::t_cmd                      i_cmd,
    output mmmed_pkg::t_stat                     o_stat,
    input  logic [mmmed_pkg::CHAN_W-1:0]         i_channel,
    input  logic [mmmed_pkg::WIDTH_W-1:0]        i_window_width,
    input  logic signed [mmmed_pkg::DATA_W-1:0]  i_sample,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [mmmed_pkg::DATA_W-1:0]  o_median_value,
    output logic [mmmed_pkg::STATUS_W-1:0]       o_status
);

    localparam int WD    = mmmed_pkg::WINDOW_DEPTH;
    localparam int DW    = mmmed_pkg::DATA_W;
    localparam int IW    = mmmed_pkg::IDX_W;
    localparam int CW    = mmmed_pkg::CNT_W;

    // captured item
    logic [mmmed_pkg::CHAN_W-1:0]   r_ch;
    logic [mmmed_pkg::WIDTH_W-1:0]  r_width;
    logic signed [DW-1:0]           r_sample;

    logic [IW-1:0]                  r_ring [mmmed_pkg::CHANNELS];
    logic [mmmed_pkg::RAM_DEPTH-1:0] r_vld;

    logic [IW-1:0]                  r_idx;
    logic                           r_load;
    logic                           r_rd_vld;
    logic [DW-1:0]                  ram_q;

    logic signed [DW-1:0]           r_lane [WD];
    logic [CW-1:0]                  r_less [WD];
    logic [CW-1:0]                  r_leq  [WD];
    logic [IW-1:0]                  r_n;

    logic signed [DW-1:0]           r_res;
    logic [mmmed_pkg::STATUS_W-1:0] r_res_st;
    logic                           r_out_valid;
    logic signed [DW-1:0]           r_out_data;
    logic [mmmed_pkg::STATUS_W-1:0] r_out_st;

    logic                           is_pass;
    logic                           is_reject;
    logic [IW-1:0]                  w_lim;
    logic [mmmed_pkg::CH_W-1:0]     ch_sel;
    logic [IW:0]                    ptr_inc;
    logic [IW-1:0]                  ptr_new;
    logic [mmmed_pkg::ADDR_W-1:0]   waddr;
    logic [mmmed_pkg::ADDR_W-1:0]   raddr;

    logic signed [DW-1:0]           x_val;
    logic [WD-1:0]                  act;
    logic [WD-1:0]                  x_lt;
    logic [WD-1:0]                  x_le;
    logic [CW-1:0]                  new_less;
    logic [CW-1:0]                  new_leq;
    logic [CW-1:0]                  rank_k;
    logic signed [DW-1:0]           med;

    assign is_pass   = (r_width == '0);
    assign is_reject = (6'(r_width) >= 6'(WD))
                    || (5'(r_ch) >= 5'(mmmed_pkg::CHANNELS));
    assign w_lim     = r_width[IW-1:0];
    assign ch_sel    = r_ch[mmmed_pkg::CH_W-1:0];

    always_comb begin
        ptr_inc = {1'b0, r_ring[ch_sel]} + 1'b1;
        ptr_new = (ptr_inc >= {1'b0, w_lim}) ? '0 : ptr_inc[IW-1:0];
    end

    assign waddr = {ch_sel, ptr_new};
    assign raddr = {ch_sel, r_idx};

    assign o_stat.is_median = !is_pass && !is_reject;
    assign o_stat.rd_last   = (r_idx == IW'(w_lim - 1'b1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    mmmed_ram #(
        .WIDTH (DW),
        .DEPTH (mmmed_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update && o_stat.is_median),
        .i_waddr (waddr),
        .i_wdata (r_sample),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch     <= i_channel;
            r_width  <= i_window_width;
            r_sample <= i_sample;
        end
        if (i_cmd.rd_en) begin
            r_rd_vld <= r_vld[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < mmmed_pkg::CHANNELS; c++) begin
                r_ring[c] <= '0;
            end
            r_vld  <= '0;
            r_idx  <= '0;
            r_load <= 1'b0;
        end else begin
            r_load <= i_cmd.rd_en;
            if (i_cmd.update) begin
                r_idx <= '0;
                if (o_stat.is_median) begin
                    r_ring[ch_sel] <= ptr_new;
                    r_vld[waddr]   <= 1'b1;
                end
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // never-written entries read as zero
    assign x_val = r_rd_vld ? $signed(ram_q) : '0;

    always_comb begin
        for (int i = 0; i < WD; i++) begin
            act[i]  = (IW'(i) < r_n);
            x_lt[i] = (x_val <  r_lane[i]);
            x_le[i] = (x_val <= r_lane[i]);
        end
        new_less = CW'($countones(act & ~x_le));
        new_leq  = CW'($countones(act & ~x_lt));
    end

    // each lane counts how many other entries sit below / at-or-below it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cmd.update) begin
            r_n <= '0;
        end else if (r_load) begin
            r_n <= r_n + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            for (int i = 0; i < WD; i++) begin
                if (act[i]) begin
                    r_less[i] <= r_less[i] + CW'(x_lt[i]);
                    r_leq[i]  <= r_leq[i]  + CW'(x_le[i]);
                end else if (IW'(i) == r_n) begin
                    r_lane[i] <= x_val;
                    r_less[i] <= new_less;
                    r_leq[i]  <= new_leq;
                end
            end
        end
    end

    assign rank_k = CW'(r_width >> 1);

    // every lane covering rank k holds the same value, so OR them together
    always_comb begin
        med = '0;
        for (int i = 0; i < WD; i++) begin
            if (act[i] && (r_less[i] <= rank_k) && (rank_k <= r_leq[i])) begin
                med = med | r_lane[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (is_pass) begin
                r_res    <= r_sample;
                r_res_st <= mmmed_pkg::ST_PASS;
            end else if (is_reject) begin
                r_res    <= '0;
                r_res_st <= mmmed_pkg::ST_REJECT;
            end
        end else if (i_cmd.select) begin
            r_res    <= med;
            r_res_st <= mmmed_pkg::ST_MEDIAN;
        end
        if (i_cmd.push) begin
            r_out_data <= r_res;
            r_out_st   <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median_value = r_out_data;
    assign o_status       = r_out_st;

endmodule

/* src/multichannel_moving_median_top.sv */
// ----------------------------------------------------------------------------
// multichannel_moving_median_top
// Per-channel moving median over a ring of recent samples.
//
//   channel  dir  tdata (low bit up)               tuser
//   s_axis   in   window_width[4:0], sample[36:5]  channel[3:0]
//   m_axis   out  median_value[31:0]               status[1:0]
//
// Between accepts a median item runs the update state, one RAM read per
// window entry, then drain, rank select and push. Passthrough and reject
// items go from the update state straight to the push. The output register
// holds a finished beat while the next item is processed; a stall only
// blocks the final push. Reset clears pointers and window valid bits, no sweep.
// ----------------------------------------------------------------------------
module multichannel_moving_median_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mmmed_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // window_width, sample
    input  logic [mmmed_pkg::CHAN_W-1:0]      s_axis_tuser,  // channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mmmed_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // median_value
    output logic [mmmed_pkg::STATUS_W-1:0]    m_axis_tuser   // status
);

    mmmed_pkg::t_cmd  cmd;
    mmmed_pkg::t_stat stat;
    logic signed [mmmed_pkg::DATA_W-1:0] med_value;

    mmmed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mmmed_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_channel      (s_axis_tuser),
        .i_window_width (s_axis_tdata[mmmed_pkg::WIDTH_W-1:0]),
        .i_sample       ($signed(s_axis_tdata[mmmed_pkg::WIDTH_W +: mmmed_pkg::DATA_W])),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_median_value (med_value),
        .o_status       (m_axis_tuser)
    );

    assign m_axis_tdata = mmmed_pkg::M_TDATA_W'(med_value);

endmodule

/* src/mmmed_checker.sv */
// ----------------------------------------------------------------------------
// mmmed_checker
// Port-level checks of the moving median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mmmed_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [mmmed_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [mmmed_pkg::CHAN_W-1:0]      s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [mmmed_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic [mmmed_pkg::STATUS_W-1:0]    m_axis_tuser
);

    // one item at a time: input side closes right after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == mmmed_pkg::ST_MEDIAN)
                       || (m_axis_tuser == mmmed_pkg::ST_PASS)
                       || (m_axis_tuser == mmmed_pkg::ST_REJECT))
        else $error("undefined status code");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == mmmed_pkg::ST_REJECT) |-> (m_axis_tdata == '0))
        else $error("rejected beat carries nonzero data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // an idle output stays idle right after an input is taken
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind multichannel_moving_median_top mmmed_checker u_mmmed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/mmmed_median_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmmed_median_checker
// Watches both stream sides of the moving median filter. Keeps its own copy
// of the window stores and ring pointers, predicts each result when a beat is
// accepted, and compares returned beats in order against those predictions.
// ----------------------------------------------------------------------------
module mmmed_median_checker
    import mmmed_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    input  logic                     i_s_axis_tready,
    input  logic [S_TDATA_W-1:0]     i_s_axis_tdata,  // window_width, sample
    input  logic [CHAN_W-1:0]        i_s_axis_tuser,  // channel
    input  logic                     i_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    input  logic [M_TDATA_W-1:0]     i_m_axis_tdata,  // median_value
    input  logic [STATUS_W-1:0]      i_m_axis_tuser,  // status
    output int                       o_outstanding,
    output int                       o_fail_count
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
    } t_median_result;

    logic signed [DATA_W-1:0] win_mem [CHANNELS][WINDOW_DEPTH];
    int                       ring_ptr [CHANNELS];
    t_median_result           pending_medians [$];
    t_median_result           predicted;
    t_median_result           oldest;
    int                       fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
        fail_total++;
    endtask

    function automatic void clear_windows();
        foreach (win_mem[c, i]) win_mem[c][i] = '0;
        foreach (ring_ptr[c]) ring_ptr[c] = 0;
    endfunction

    // For a median item, advance the channel's ring, store the sample, select rank width/2.
    function automatic t_median_result predict_median(input logic [CHAN_W-1:0] ch,
                                                      input logic [WIDTH_W-1:0] w,
                                                      input logic signed [DATA_W-1:0] smp);
        t_median_result res;
        int             c;
        int             n;
        int             k;
        int             nxt;
        int             below;
        int             same;

        res = '{value: '0, status: ST_MEDIAN};
        c = int'(ch);
        n = int'(w);
        if (n == 0) begin
            res.value  = smp;
            res.status = ST_PASS;
            return res;
        end
        if (c >= CHANNELS || n >= WINDOW_DEPTH) begin
            res.status = ST_REJECT;
            return res;
        end
        nxt = ring_ptr[c] + 1;
        if (nxt >= n) nxt = 0;
        ring_ptr[c]     = nxt;
        win_mem[c][nxt] = smp;
        k = n / 2;
        for (int i = 0; i < n; i++) begin
            below = 0;
            same  = 0;
            for (int j = 0; j < n; j++) begin
                if (win_mem[c][j] < win_mem[c][i]) below++;
                else if (win_mem[c][j] == win_mem[c][i]) same++;
            end
            if (below <= k && k < below + same) res.value = win_mem[c][i];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_windows();
            pending_medians.delete();
        end else begin
            // retire before predicting so a stray beat cannot hide behind a new one
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_medians.size() == 0) begin
                    report_mismatch("result beat with nothing pending",
                                    i_m_axis_tdata[DATA_W-1:0], '0);
                end else begin
                    oldest = pending_medians.pop_front();
                    if (i_m_axis_tdata[DATA_W-1:0] !== oldest.value)
                        report_mismatch("median_value", i_m_axis_tdata[DATA_W-1:0],
                                        oldest.value);
                    if (i_m_axis_tuser !== oldest.status)
                        report_mismatch("status", DATA_W'(i_m_axis_tuser),
                                        DATA_W'(oldest.status));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predicted = predict_median(i_s_axis_tuser,
                                           i_s_axis_tdata[WIDTH_W-1:0],
                                           i_s_axis_tdata[WIDTH_W +: DATA_W]);
                pending_medians.push_back(predicted);
            end
        end
        o_outstanding <= pending_medians.size();
    end

endmodule

/* verif/multichannel_moving_median_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_moving_median_top_tb
// Drives directed and random sample beats into the moving median filter with
// random gaps on both sides and one long output stall, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module multichannel_moving_median_top_tb;
    import mmmed_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // window_width[4:0], sample[36:5]
    logic [CHAN_W-1:0]     s_axis_tuser;   // channel[3:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // median_value[31:0]
    logic [STATUS_W-1:0]   m_axis_tuser;   // status[1:0]

    int   outstanding;
    int   fail_count;
    int   idle_cycles = 0;
    logic tx_steady   = 1'b0;
    logic rx_steady   = 1'b0;
    int   chan_width [CHANNELS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multichannel_moving_median_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mmmed_median_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_outstanding   (outstanding),
        .o_fail_count    (fail_count)
    );

    task automatic send_sample(input int ch, input int w, input logic [DATA_W-1:0] smp);
        int gap;

        gap = tx_steady ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= CHAN_W'(ch);
        s_axis_tdata  <= S_TDATA_W'({smp, WIDTH_W'(w)});
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Half wide random values, with narrow ranges to force ties and the extremes.
    function automatic logic [DATA_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            5, 6, 7: return DATA_W'($signed($urandom_range(0, 8)) - 4);
            8:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            9:       return DATA_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_sample();
        int ch;
        int w;

        case ($urandom_range(0, 19))
            0: begin
                ch = $urandom_range(0, 15);
                w  = 0;
            end
            1: begin
                ch = $urandom_range(CHANNELS, 15);
                w  = $urandom_range(1, 31);
            end
            2: begin
                ch = $urandom_range(0, 15);
                w  = $urandom_range(WINDOW_DEPTH, 31);
            end
            default: begin
                // hold a width per channel for a while so the rings fill and wrap
                ch = $urandom_range(0, CHANNELS - 1);
                if ($urandom_range(0, 9) == 0)
                    chan_width[ch] = $urandom_range(1, WINDOW_DEPTH - 1);
                w = chan_width[ch];
            end
        endcase
        send_sample(ch, w, draw_sample());
    endtask

    // Receiver: random holds per beat, steady stretches, one long stall.
    initial begin
        int gap;
        int taken;

        m_axis_tready = 1'b0;
        taken = 0;
        forever begin
            if (taken % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
            gap = rx_steady ? 0 : $urandom_range(0, 11);
            if (taken == 150) gap = LONG_HOLD;
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    // Watchdog: stop when nothing moves on either side for too long.
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        foreach (chan_width[c]) chan_width[c] = $urandom_range(1, WINDOW_DEPTH - 1);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // passthrough on any channel, and rejects on channel and width
        send_sample(0, 0, 32'h7FFF_FFFF);
        send_sample(15, 0, 32'h8000_0000);
        send_sample(8, 3, 32'h0000_0011);
        send_sample(15, 31, 32'hFFFF_FFFF);
        send_sample(0, WINDOW_DEPTH, 32'h1234_5678);
        // single-entry window and short history with cleared entries
        send_sample(0, 1, 32'h8000_0000);
        send_sample(1, WINDOW_DEPTH - 1, 32'd5);
        send_sample(1, WINDOW_DEPTH - 1, -32'sd7);
        // even width takes the upper median
        send_sample(2, 2, 32'd9);
        send_sample(2, 2, -32'sd3);
        // ties
        send_sample(3, 3, 32'd4);
        send_sample(3, 3, 32'd4);
        send_sample(3, 3, 32'd4);
        send_sample(3, 3, -32'sd1);
        // width change on a live channel, up then down
        send_sample(2, 5, 32'd1);
        send_sample(2, 2, 32'hFFFF_FFFF);
        send_sample(7, WINDOW_DEPTH - 1, 32'h7FFF_FFFF);
        send_sample(7, WINDOW_DEPTH - 1, 32'h8000_0000);
        send_sample(4, 1, 32'h1234_5678);
        send_sample(5, WINDOW_DEPTH - 2, 32'hAAAA_AAAA);
        send_sample(5, WINDOW_DEPTH - 2, 32'h5555_5555);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) tx_steady = ($urandom_range(0, 3) == 0);
            send_random_sample();
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        do @(negedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
